// ===== hdl/mlqs_pkg.sv =====
// Package: shared types and constants of the multilevel queue scheduler.
package mlqs_pkg;
  localparam int TimeW = 24;
  localparam logic [TimeW-1:0] TimeMax = 24'hFFFFFF;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_PRIO  = 2'd1,
    POL_SHORT = 2'd2,
    POL_RR    = 2'd3
  } pol_t;

  typedef enum logic [2:0] {
    CFG_QUANTUM = 3'd0,
    CFG_Q0      = 3'd1,
    CFG_Q1      = 3'd2,
    CFG_Q2      = 3'd3,
    CFG_Q3      = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EXEC,
    ST_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic append;
    logic restart;
    logic scan_start;
    logic scan_step;
    logic exec;
    logic advance;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic all_fin;
    logic keep_running;
    logic scan_last;
    logic found;
  } dp_stat_t;

  typedef struct packed {
    logic             ran;
    logic [4:0]       task_id;
    logic [1:0]       queue_number;
    logic             task_done;
    logic [TimeW-1:0] completion_tick;
    logic [TimeW-1:0] turnaround;
    logic [TimeW-1:0] waiting;
    logic [TimeW-1:0] tick_time;
    logic             all_done;
  } result_t;
endpackage

// ===== hdl/mlqs_if.sv =====
// Interfaces: input, result and configuration channels.
interface mlqs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] arrive_tick;
  logic [15:0] work_ticks;
  logic [7:0]  task_priority;
  modport source (output valid, cmd, arrive_tick, work_ticks, task_priority, input ready);
  modport sink (input valid, cmd, arrive_tick, work_ticks, task_priority, output ready);
endinterface

interface mlqs_out_if;
  logic        valid;
  logic        ready;
  logic        ran;
  logic [4:0]  task_id;
  logic [1:0]  queue_number;
  logic        task_done;
  logic [23:0] completion_tick;
  logic [23:0] turnaround;
  logic [23:0] waiting;
  logic [23:0] tick_time;
  logic        all_done;
  modport source (output valid, ran, task_id, queue_number, task_done, completion_tick,
                  turnaround, waiting, tick_time, all_done, input ready);
  modport sink (input valid, ran, task_id, queue_number, task_done, completion_tick,
                turnaround, waiting, tick_time, all_done, output ready);
endinterface

interface mlqs_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/mlqs_ctrl.sv =====
// Controller: sequences a tick word through check, scan, execute and output.
module mlqs_ctrl import mlqs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [1:0] in_cmd,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (cmd_t'(in_cmd))
            CMD_CLEAR:   cmd.clear = 1'b1;
            CMD_APPEND:  cmd.append = 1'b1;
            CMD_RESTART: cmd.restart = 1'b1;
            default:     state_next = ST_CHECK;
          endcase
        end
      end
      ST_CHECK: begin
        if (stat.all_fin) begin
          cmd.load_out = 1'b1;
          state_next = ST_OUT;
        end else if (stat.keep_running) begin
          state_next = ST_EXEC;
        end else begin
          cmd.scan_start = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        cmd.advance = 1'b1;
        cmd.load_out = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== hdl/mlqs_dp.sv =====
// Datapath: task table, selection scan, time keeping and result register.
module mlqs_dp import mlqs_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [15:0] arrive_tick,
  input  logic [15:0] work_ticks,
  input  logic [7:0]  task_priority,
  input  logic [7:0]  rr_quantum,
  input  pol_t        policy [4],
  output result_t     result
);
  localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CntW = $clog2(MAX_TASKS + 1);
  // scan covers queue*MAX_TASKS+entry, 4 queues
  localparam int ScanW = IdxW + 2;

  logic [15:0]      t_arr [MAX_TASKS];
  logic [15:0]      t_bur [MAX_TASKS];
  logic [7:0]       t_pri [MAX_TASKS];
  logic [15:0]      t_rem [MAX_TASKS];
  logic [TimeW-1:0] t_last [MAX_TASKS];
  logic [MAX_TASKS-1:0] t_fin;

  logic [CntW-1:0]  count;
  logic [TimeW-1:0] now;
  logic [7:0]       slice;
  logic             run_valid;
  logic [IdxW-1:0]  run_idx;

  logic [1:0]       scan_q;
  logic [IdxW-1:0]  scan_i;
  logic             best_ok;
  logic [IdxW-1:0]  best;
  logic [TimeW-1:0] best_key;
  logic [15:0]      best_arr;
  logic             sel_ok;
  logic [IdxW-1:0]  sel;
  logic             sel_new;

  // All entries in the table finished
  logic all_fin;
  always_comb begin
    all_fin = 1'b1;
    for (int k = 0; k < MAX_TASKS; k++)
      if (CntW'(k) < count && !t_fin[k]) all_fin = 1'b0;
  end

  logic [1:0] run_q;
  assign run_q = 2'(run_idx);
  logic keep;
  assign keep = run_valid && (CntW'(run_idx) < count) && !t_fin[run_idx] &&
                (policy[run_q] != POL_RR || slice != 8'd0);

  // Scan candidate
  pol_t             sp;
  logic [TimeW-1:0] ckey;
  logic             cand;
  assign sp = policy[scan_q];
  always_comb begin
    case (sp)
      POL_FCFS:  ckey = TimeW'(t_arr[scan_i]);
      POL_PRIO:  ckey = TimeW'(t_pri[scan_i]);
      POL_SHORT: ckey = TimeW'(t_rem[scan_i]);
      default:   ckey = t_last[scan_i];
    endcase
  end
  assign cand = (CntW'(scan_i) < count) && (2'(scan_i) == scan_q) && !t_fin[scan_i] &&
                (TimeW'(t_arr[scan_i]) <= now);
  logic better;
  assign better = !best_ok || ckey < best_key ||
                  (ckey == best_key && t_arr[scan_i] < best_arr);
  logic last_i;
  assign last_i = (scan_i == IdxW'(MAX_TASKS - 1));
  logic found_now;
  assign found_now = best_ok || cand;

  assign stat.all_fin = all_fin;
  assign stat.keep_running = keep;
  assign stat.scan_last = last_i && (found_now || scan_q == 2'd3);
  assign stat.found = sel_ok;

  // Execute arithmetic
  logic [IdxW-1:0]  ex;
  logic [TimeW-1:0] comp, tat, wt;
  pol_t             ep;
  assign ex = sel;
  assign ep = policy[2'(ex)];
  assign comp = (now >= TimeMax) ? TimeMax : now + 1'b1;
  assign tat = comp - TimeW'(t_arr[ex]);
  assign wt = (tat > TimeW'(t_bur[ex])) ? tat - TimeW'(t_bur[ex]) : '0;

  // Table and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      now <= '0;
      slice <= '0;
      run_valid <= 1'b0;
      run_idx <= '0;
      t_fin <= '0;
      sel_ok <= 1'b0;
      sel_new <= 1'b0;
      for (int k = 0; k < MAX_TASKS; k++) t_last[k] <= '0;
    end else begin
      if (cmd.clear || cmd.restart) begin
        if (cmd.clear) count <= '0;
        now <= '0;
        slice <= '0;
        run_valid <= 1'b0;
        run_idx <= '0;
        t_fin <= '0;
        for (int k = 0; k < MAX_TASKS; k++) begin
          t_rem[k] <= t_bur[k];
          t_last[k] <= '0;
        end
      end
      if (cmd.append && count < CntW'(MAX_TASKS)) begin
        t_arr[IdxW'(count)] <= arrive_tick;
        t_bur[IdxW'(count)] <= work_ticks;
        t_pri[IdxW'(count)] <= task_priority;
        t_rem[IdxW'(count)] <= work_ticks;
        t_last[IdxW'(count)] <= '0;
        t_fin[IdxW'(count)] <= 1'b0;
        count <= count + 1'b1;
      end
      // Not all finished and no keep: choose via scan; keep: reuse running
      if (!cmd.scan_start && !cmd.scan_step && !cmd.exec) begin
        sel_ok <= keep;
        sel <= run_idx;
        sel_new <= 1'b0;
      end
      if (cmd.scan_start) begin
        run_valid <= 1'b0;
        scan_q <= 2'd0;
        scan_i <= '0;
        best_ok <= 1'b0;
        sel_ok <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (cand && better) begin
          best_ok <= 1'b1;
          best <= scan_i;
          best_key <= ckey;
          best_arr <= t_arr[scan_i];
        end
        if (last_i) begin
          sel_ok <= found_now;
          sel_new <= 1'b1;
          sel <= (cand && better) ? scan_i : best;
          scan_i <= '0;
          scan_q <= scan_q + 1'b1;
        end else begin
          scan_i <= scan_i + 1'b1;
        end
      end
      if (cmd.exec && sel_ok) begin
        logic [7:0] sl;
        logic       rv;
        sl = slice;
        rv = run_valid;
        if (sel_new) begin
          rv = 1'b1;
          run_idx <= sel;
          if (ep == POL_RR) sl = (rr_quantum != 8'd0) ? rr_quantum : 8'd1;
        end
        if (ep == POL_RR && sl != 8'd0) sl = sl - 1'b1;
        slice <= sl;
        t_last[ex] <= now;
        if (t_rem[ex] <= 16'd1) begin
          t_rem[ex] <= '0;
          t_fin[ex] <= 1'b1;
          rv = 1'b0;
        end else begin
          t_rem[ex] <= t_rem[ex] - 1'b1;
          if (ep == POL_RR && sl == 8'd0) rv = 1'b0;
        end
        run_valid <= rv;
      end
      if (cmd.advance && now < TimeMax) now <= now + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    result_t r;
    r = '0;
    r.tick_time = now;
    if (cmd.exec) begin
      if (sel_ok) begin
        r.ran = 1'b1;
        r.task_id = 5'((6'(ex) + 6'd1));
        r.queue_number = 2'(ex);
        if (t_rem[ex] <= 16'd1) begin
          r.task_done = 1'b1;
          r.completion_tick = comp;
          r.turnaround = tat;
          r.waiting = wt;
        end
      end
    end else begin
      r.all_done = 1'b1;
    end
    if (cmd.load_out) result <= r;
  end
endmodule

// ===== hdl/multilevel_queue_task_scheduler.sv =====
// Top level of the multilevel queue task scheduler.
// Input channel "in" carries a command word: clear, append, restart or tick.
// Clear, append and restart give no result word.
// A tick gives exactly one result word on "out": the executed task, its queue,
// completion data when it finishes, the tick time, or all_done when every
// task has finished (time then holds).
// A tick goes from check straight to execute when the running task keeps
// the processor and straight to output when all are finished; when a new
// task must be chosen, the scan visits one table entry per cycle per queue,
// stopping after the first queue that holds a ready task. Next word is
// taken once the result has been accepted.
// Configuration "cfg" writes the round robin quantum (index 0) and queue
// policies (indexes 1 to 4) at any time; it is always ready.
// Reset (rst, synchronous) empties the table, zeroes time and loads the
// register defaults. While the receiver stalls the result is held and
// no input word is taken.
module multilevel_queue_task_scheduler import mlqs_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input logic clk,
  input logic rst,
  mlqs_in_if.sink   in,
  mlqs_out_if.source out,
  mlqs_cfg_if.sink  cfg
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  res;
  logic [7:0] quantum;
  pol_t policy [4];

  // Configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= 8'd2;
      policy[0] <= POL_FCFS;
      policy[1] <= POL_PRIO;
      policy[2] <= POL_SHORT;
      policy[3] <= POL_RR;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_QUANTUM: quantum <= cfg.data;
        CFG_Q0: policy[0] <= pol_t'(cfg.data[1:0]);
        CFG_Q1: policy[1] <= pol_t'(cfg.data[1:0]);
        CFG_Q2: policy[2] <= pol_t'(cfg.data[1:0]);
        CFG_Q3: policy[3] <= pol_t'(cfg.data[1:0]);
        default: ;
      endcase
    end
  end

  mlqs_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in.valid), .in_ready(in.ready), .in_cmd(in.cmd),
    .out_valid(out.valid), .out_ready(out.ready),
    .cmd, .stat
  );

  mlqs_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .arrive_tick(in.arrive_tick), .work_ticks(in.work_ticks),
    .task_priority(in.task_priority),
    .rr_quantum(quantum), .policy, .result(res)
  );

  assign out.ran = res.ran;
  assign out.task_id = res.task_id;
  assign out.queue_number = res.queue_number;
  assign out.task_done = res.task_done;
  assign out.completion_tick = res.completion_tick;
  assign out.turnaround = res.turnaround;
  assign out.waiting = res.waiting;
  assign out.tick_time = res.tick_time;
  assign out.all_done = res.all_done;
endmodule

// ===== hdl/mlqs_checker.sv =====
// Checker: port level properties of the scheduler, bound to the top level.
module mlqs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic ran,
  input logic task_done,
  input logic all_done,
  input logic [4:0] task_id
);
  // No new word is taken while a result waits
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  // A stalled result stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  // Completion only for a task that ran
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && task_done |-> ran) else $error("done without run");
  // Idle or all done reports task id zero
  a_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && (all_done || !ran) |-> task_id == 5'd0) else $error("bad id");
endmodule

bind multilevel_queue_task_scheduler mlqs_checker u_checker (
  .clk(clk), .rst(rst),
  .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready),
  .ran(out.ran), .task_done(out.task_done), .all_done(out.all_done),
  .task_id(out.task_id)
);

// ===== verif/mlqs_checker.sv =====
// Checker: watches the scheduler's channels, predicts each tick result and compares.
`timescale 1ns / 100ps
module mlqs_tb_checker import mlqs_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic clk,
  input  logic rst,
  mlqs_in_if   in,
  mlqs_out_if  out,
  mlqs_cfg_if  cfg,
  output int   fail_count,
  output int   pending,
  output int   ticks_seen,
  output int   finishes_seen
);
  // scheduler image
  logic [7:0]  quantum;
  pol_t        qpol [4];
  logic [15:0] t_arr [MAX_TASKS];
  logic [15:0] t_bur [MAX_TASKS];
  logic [7:0]  t_pri [MAX_TASKS];
  logic [15:0] t_rem [MAX_TASKS];
  logic [23:0] t_last [MAX_TASKS];
  logic        t_fin [MAX_TASKS];
  logic [7:0]  slice;
  int          count;
  logic [23:0] now;
  logic        run_v;
  int          run_i;
  result_t     expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [23:0] sort_key(int i, pol_t p);
    case (p)
      POL_FCFS:  return 24'(t_arr[i]);
      POL_PRIO:  return 24'(t_pri[i]);
      POL_SHORT: return 24'(t_rem[i]);
      default:   return t_last[i];
    endcase
  endfunction

  function automatic void restart_run();
    now = '0; run_v = 0; run_i = 0; slice = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      t_rem[i] = t_bur[i]; t_fin[i] = 0; t_last[i] = '0;
    end
  endfunction

  // one time unit of task i
  function automatic void run_task(int i, pol_t p, ref result_t r);
    logic [23:0] comp, tat;
    t_last[i] = now;
    r.ran = 1; r.task_id = 5'(i + 1); r.queue_number = 2'(i % 4);
    if (p == POL_RR && slice > 0) slice--;
    if (t_rem[i] <= 1) begin
      comp = (now == TimeMax) ? TimeMax : now + 1;
      tat = comp - 24'(t_arr[i]);
      t_rem[i] = 0; t_fin[i] = 1; run_v = 0;
      r.task_done = 1; r.completion_tick = comp; r.turnaround = tat;
      r.waiting = (tat > 24'(t_bur[i])) ? tat - 24'(t_bur[i]) : '0;
    end else begin
      t_rem[i]--;
      if (p == POL_RR && slice == 0) run_v = 0;
    end
  endfunction

  function automatic result_t tick_outcome();
    result_t r;
    logic all_fin;
    int best;
    pol_t p;
    r = '0; r.tick_time = now; all_fin = 1;
    for (int i = 0; i < count; i++) if (!t_fin[i]) all_fin = 0;
    if (all_fin) begin
      r.all_done = 1;
      return r;
    end
    if (run_v && run_i < count && !t_fin[run_i]) begin
      p = qpol[run_i % 4];
      if (p != POL_RR || slice > 0) begin
        run_task(run_i, p, r);
        if (now != TimeMax) now++;
        return r;
      end
    end
    run_v = 0;
    for (int q = 0; q < 4; q++) begin
      best = -1; p = qpol[q];
      for (int i = q; i < count; i += 4) begin
        if (t_fin[i] || 24'(t_arr[i]) > now) continue;
        if (best < 0 || sort_key(i, p) < sort_key(best, p) ||
            (sort_key(i, p) == sort_key(best, p) && t_arr[i] < t_arr[best]))
          best = i;
      end
      if (best >= 0) begin
        run_v = 1; run_i = best;
        if (p == POL_RR) slice = (quantum != 0) ? quantum : 8'd1;
        run_task(best, p, r);
        break;
      end
    end
    if (now != TimeMax) now++;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got, exp_r;
    if (rst) begin
      quantum <= 8'd2;
      qpol[0] = POL_FCFS; qpol[1] = POL_PRIO; qpol[2] = POL_SHORT; qpol[3] = POL_RR;
      for (int i = 0; i < MAX_TASKS; i++) begin
        t_arr[i] = '0; t_bur[i] = '0; t_pri[i] = '0;
      end
      count = 0; restart_run();
      expected_results.delete();
      fail_count <= 0; ticks_seen <= 0; finishes_seen <= 0;
    end else begin
      // register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_t'(cfg.index))
          CFG_QUANTUM: quantum <= cfg.data;
          CFG_Q0:      qpol[0] = pol_t'(cfg.data[1:0]);
          CFG_Q1:      qpol[1] = pol_t'(cfg.data[1:0]);
          CFG_Q2:      qpol[2] = pol_t'(cfg.data[1:0]);
          CFG_Q3:      qpol[3] = pol_t'(cfg.data[1:0]);
          default: ;
        endcase
      end
      // command words
      if (in.valid && in.ready) begin
        case (cmd_t'(in.cmd))
          CMD_CLEAR: begin count = 0; restart_run(); end
          CMD_APPEND: if (count < MAX_TASKS) begin
            t_arr[count] = in.arrive_tick; t_bur[count] = in.work_ticks;
            t_pri[count] = in.task_priority; t_rem[count] = in.work_ticks;
            t_last[count] = '0; t_fin[count] = 0; count++;
          end
          CMD_RESTART: restart_run();
          default: expected_results = {expected_results, tick_outcome()};
        endcase
      end
      // result words
      if (out.valid && out.ready) begin
        got = '{out.ran, out.task_id, out.queue_number, out.task_done, out.completion_tick,
                out.turnaround, out.waiting, out.tick_time, out.all_done};
        ticks_seen <= ticks_seen + 1;
        if (got.task_done) finishes_seen <= finishes_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result word %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            $display("%0t mismatch: expected %p actual %p", $time, exp_r, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== verif/tb_multilevel_queue_task_scheduler.sv =====
// Testbench top: drives commands and register writes, gives the verdict.
`timescale 1ns / 100ps
module tb_multilevel_queue_task_scheduler import mlqs_pkg::*; ();

  localparam int MaxTasks = 16;
  localparam int StallLimit = 4000;

  logic clk;
  logic rst;
  int   fail_count, pending, ticks_seen, finishes_seen;
  int   idle_cycles;

  mlqs_in_if  in_ch ();
  mlqs_out_if out_ch ();
  mlqs_cfg_if cfg_ch ();

  multilevel_queue_task_scheduler #(.MAX_TASKS(MaxTasks)) DUT (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source), .cfg(cfg_ch.sink)
  );

  mlqs_tb_checker #(.MAX_TASKS(MaxTasks)) u_checker (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch), .cfg(cfg_ch),
    .fail_count(fail_count), .pending(pending), .ticks_seen(ticks_seen),
    .finishes_seen(finishes_seen)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no progress, %0d results outstanding", pending);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall before each word, sometimes none at all
  initial begin
    int gap;
    out_ch.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_word(cmd_t c, logic [15:0] a, logic [15:0] b, logic [7:0] p);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1; in_ch.cmd <= c;
    in_ch.arrive_tick <= a; in_ch.work_ticks <= b; in_ch.task_priority <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic quiesce();
    in_ch.valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4 * MaxTasks + 8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] d);
    cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  task automatic append(logic [15:0] a, logic [15:0] b, logic [7:0] p);
    send_word(CMD_APPEND, a, b, p);
  endtask

  task automatic tick();
    send_word(CMD_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  initial begin
    int items, phase, n;
    rst = 1;
    in_ch.valid = 0; in_ch.cmd = CMD_CLEAR;
    in_ch.arrive_tick = 0; in_ch.work_ticks = 0; in_ch.task_priority = 0;
    cfg_ch.valid = 0; cfg_ch.index = CFG_QUANTUM; cfg_ch.data = 0;
    repeat (11) @(negedge clk);
    rst = 0;

    // directed: empty table, extremes, zero burst, full table, restart
    tick();
    append(16'd0, 16'd0, 8'd0);
    append(16'hFFFF, 16'hFFFF, 8'hFF);
    append(16'd1, 16'd3, 8'h80);
    append(16'd0, 16'd2, 8'd7);
    append(16'd0, 16'd1, 8'd1);
    repeat (6) tick();
    for (int i = 0; i < 12; i++) append(16'(i % 3), 16'(i % 4), 8'(i));
    tick();
    send_word(CMD_RESTART, 16'hFFFF, 16'hFFFF, 8'hFF);
    tick();
    send_word(CMD_CLEAR, 16'h5555, 16'hAAAA, 8'h5A);
    tick();
    items = 29;

    // random phases, each with its own register setting
    phase = 0;
    while (items < 550) begin
      quiesce();
      case (phase % 4)
        0: write_reg(CFG_QUANTUM, 8'd0);
        1: write_reg(CFG_QUANTUM, 8'hFF);
        default: write_reg(CFG_QUANTUM, 8'($urandom_range(1, 5)));
      endcase
      write_reg(CFG_Q0, (phase < 4) ? 8'(phase) : 8'($urandom_range(0, 3)));
      write_reg(CFG_Q1, 8'($urandom_range(0, 3)));
      write_reg(CFG_Q2, 8'($urandom_range(0, 3)));
      write_reg(CFG_Q3, (phase == 1) ? 8'd0 : 8'(POL_RR));
      send_word(CMD_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom));
      n = $urandom_range(1, 17);
      for (int i = 0; i < n; i++)
        append(16'($urandom_range(0, 12)),
               ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
               8'($urandom));
      items += n + 1;
      for (int i = 0; i < 40; i++) begin
        n = $urandom_range(0, 29);
        if (n == 0) send_word(CMD_RESTART, 16'($urandom), 16'($urandom), 8'($urandom));
        else if (n == 1)
          append(16'($urandom_range(0, 60)), 16'($urandom_range(0, 4)), 8'($urandom));
        else tick();
        items++;
      end
      phase++;
    end
    quiesce();
    $display("covered %0d command words in %0d register settings", items, phase + 1);
    $display("checked %0d tick results, %0d task completions", ticks_seen, finishes_seen);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/mlqs_pkg.sv
hdl/mlqs_if.sv
hdl/mlqs_ctrl.sv
hdl/mlqs_dp.sv
hdl/multilevel_queue_task_scheduler.sv
hdl/mlqs_checker.sv
verif/mlqs_checker.sv
verif/tb_multilevel_queue_task_scheduler.sv
